// ----- rtl/pps_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg
// Shared widths, codes, the arctangent table and small helpers for the
// pure pursuit steering block.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int CORDIC_STEPS_DEF = 24;

    // CORDIC datapath: x/y hold up to about 2^34, z a wrapped binary angle
    localparam int CW = 36;
    localparam int ZW = 34;

    // serial multiplier operands and product
    localparam int MW = 32;
    localparam int PW = 2 * MW;

    // square root of a 65-bit sum of squares
    localparam int SQ_IN_W = 65;
    localparam int ROOT_W  = 33;
    localparam int SQ_REM_W = 37;

    // divider for the arc turn rate
    localparam int DIV_NW = 53;
    localparam int DIV_DW = 47;

    localparam logic signed [CW-1:0] GAIN_Q30 = 36'sd652032874;
    localparam logic [MW-1:0] PI_Q29 = 32'd1686629713;
    localparam logic signed [31:0] QUARTER = 32'sh40000000;
    localparam logic signed [31:0] NEG_QUARTER = -32'sh40000000;

    // result status codes
    localparam logic [2:0] ST_ARC      = 3'd0;
    localparam logic [2:0] ST_GOAL     = 3'd1;
    localparam logic [2:0] ST_NOPATH   = 3'd2;
    localparam logic [2:0] ST_STRAIGHT = 3'd3;
    localparam logic [2:0] ST_SHARP    = 3'd4;

    // CORDIC modes
    localparam logic CM_VECTOR = 1'b0;
    localparam logic CM_ROTATE = 1'b1;

    function automatic logic [31:0] atan_bam(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0: v = 32'h20000000;  5'd1: v = 32'h12E4051E;
            5'd2: v = 32'h09FB385B;  5'd3: v = 32'h051111D4;
            5'd4: v = 32'h028B0D43;  5'd5: v = 32'h0145D7E1;
            5'd6: v = 32'h00A2F61E;  5'd7: v = 32'h00517C55;
            5'd8: v = 32'h0028BE53;  5'd9: v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98; 5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6; 5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA; 5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE; 5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30; 5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C; 5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3; 5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029; 5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A; 5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003; 5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // clamp a magnitude with sign into the signed 32-bit range
    function automatic logic [31:0] sat_s32(input logic [63:0] mag, input logic neg);
        logic [31:0] r;
        if (neg) begin
            r = (mag >= 64'h80000000) ? 32'h80000000 : 32'(-mag);
        end else begin
            r = (mag > 64'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] abs_s33(input logic signed [32:0] v);
        logic [32:0] m;
        m = v[32] ? 33'(-v) : 33'(v);
        return m[31:0];
    endfunction

endpackage

// ----- rtl/pure_pursuit_steering.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pure_pursuit_steering
// Streamed pure pursuit: tracks the lookahead target over a path and emits
// one velocity command per path.
// ----------------------------------------------------------------------------
// Path points enter on the s_ channel (valid/ready), one request per point,
// tagged first/last; the first point also carries the robot pose. A point
// with path_empty set yields a no-path result at once. The last point
// yields one result on the m_ channel; other points yield none.
// Configuration is an APB slave: lookahead at 0x0, goal tolerance at 0x4,
// speed at 0x8; write only while the block is idle.
// Each point runs through the serial units (shift-add multiplier, root,
// CORDIC, divider): an ordinary point takes the multiplier and the root;
// the first point adds a CORDIC pass for the yaw; a sharp last point adds
// a CORDIC pass and two multiplies; an arc last point adds two CORDIC
// passes, two multiplies, the root and the divider.
// Points are taken one at a time. A finished result sits in the output
// register; the next point is accepted meanwhile, and its own result waits
// while the receiver stalls. Reset loads the register defaults and clears
// the held pose, previous point and target.
// ----------------------------------------------------------------------------
module pure_pursuit_steering
    import pps_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_point_x,
    input  logic signed [31:0] s_point_y,
    input  logic               s_first_point,
    input  logic               s_last_point,
    input  logic               s_path_empty,
    input  logic signed [31:0] s_robot_x,
    input  logic signed [31:0] s_robot_y,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    input  logic signed [15:0] s_quat_w,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [20:0]        m_forward_velocity,
    output logic signed [31:0] m_turn_rate,
    output logic [2:0]         m_status
);

    localparam logic [1:0] REG_LOOKAHEAD = 2'd0;
    localparam logic [1:0] REG_TOLERANCE = 2'd1;
    localparam logic [1:0] REG_SPEED     = 2'd2;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_QSUM   = 5'd1;
    localparam logic [4:0] S_YAW    = 5'd2;
    localparam logic [4:0] S_DIST   = 5'd3;
    localparam logic [4:0] S_DMUL   = 5'd4;
    localparam logic [4:0] S_DSQRT  = 5'd5;
    localparam logic [4:0] S_LOOK   = 5'd6;
    localparam logic [4:0] S_TGT    = 5'd7;
    localparam logic [4:0] S_TANG   = 5'd8;
    localparam logic [4:0] S_HEAD   = 5'd9;
    localparam logic [4:0] S_SHARP1 = 5'd10;
    localparam logic [4:0] S_SHARP2 = 5'd11;
    localparam logic [4:0] S_SINE   = 5'd12;
    localparam logic [4:0] S_SMUL   = 5'd13;
    localparam logic [4:0] S_TMUL   = 5'd14;
    localparam logic [4:0] S_TSQRT  = 5'd15;
    localparam logic [4:0] S_DIV    = 5'd16;
    localparam logic [4:0] S_OUT    = 5'd17;

    logic [4:0]  state_reg;
    logic [4:0]  state_next;

    logic [30:0] la_reg;
    logic [30:0] tol_reg;
    logic [20:0] spd_reg;

    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;
    logic               first_reg;
    logic               last_reg;
    logic signed [31:0] qa_reg;
    logic signed [31:0] qb_reg;
    logic signed [31:0] qc_reg;
    logic signed [31:0] qd_reg;

    logic signed [31:0] held_x_reg;
    logic signed [31:0] held_y_reg;
    logic [31:0]        yaw_reg;
    logic signed [31:0] prev_x_reg;
    logic signed [31:0] prev_y_reg;
    logic [31:0]        prevd_reg;
    logic               tf_reg;
    logic signed [31:0] tx_reg;
    logic signed [31:0] ty_reg;

    logic [ROOT_W-1:0]  d_reg;
    logic signed [32:0] tdx_reg;
    logic signed [32:0] tdy_reg;
    logic signed [31:0] dd_reg;
    logic               sneg_reg;
    logic [DIV_NW-1:0]  num_reg;

    logic [20:0]        res_spd_reg;
    logic [31:0]        res_turn_reg;
    logic [2:0]         res_status_reg;
    logic               m_valid_reg;
    logic [20:0]        m_spd_reg;
    logic [31:0]        m_turn_reg;
    logic [2:0]         m_status_reg;

    logic               s_acc;
    logic               cfg_wr;
    logic               out_load;

    logic                 mul_start;
    logic [MW-1:0]        mul_a0;
    logic [MW-1:0]        mul_b0;
    logic [MW-1:0]        mul_a1;
    logic [MW-1:0]        mul_b1;
    logic                 mul_busy;
    logic                 mul_done;
    logic [PW-1:0]        mul_p0;
    logic [PW-1:0]        mul_p1;
    logic                 sq_start;
    logic [SQ_IN_W-1:0]   sq_in;
    logic                 sq_done;
    logic [ROOT_W-1:0]    sq_root;
    logic                 cor_start;
    logic                 cor_mode;
    logic signed [CW-1:0] cor_x;
    logic signed [CW-1:0] cor_y;
    logic signed [ZW-1:0] cor_z;
    logic                 cor_busy;
    logic                 cor_done;
    logic signed [CW-1:0] cor_yo;
    logic signed [ZW-1:0] cor_zo;
    logic                 div_start;
    logic                 div_done;
    logic [DIV_NW-1:0]    div_q;

    logic signed [32:0] pdx;
    logic signed [32:0] pdy;
    logic signed [32:0] tdx;
    logic signed [32:0] tdy;
    logic signed [31:0] q_num;
    logic signed [31:0] q_den;
    logic [32:0]        la33;
    logic [32:0]        prev33;
    logic               hit;
    logic [32:0]        cerr;
    logic [32:0]        nerr;
    logic               at_goal;
    logic               sharp;
    logic [31:0]        dm;
    logic [31:0]        spd20;
    logic [CW-1:0]      s_mag;

    assign s_acc    = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    always_comb begin
        case (paddr[3:2])
            REG_LOOKAHEAD: prdata = {1'b0, la_reg};
            REG_TOLERANCE: prdata = {1'b0, tol_reg};
            REG_SPEED:     prdata = {11'b0, spd_reg};
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        pdx    = 33'(px_reg) - 33'(held_x_reg);
        pdy    = 33'(py_reg) - 33'(held_y_reg);
        tdx    = 33'(tf_reg ? tx_reg : px_reg) - 33'(held_x_reg);
        tdy    = 33'(tf_reg ? ty_reg : py_reg) - 33'(held_y_reg);
        q_num  = (qa_reg + qb_reg) <<< 1;
        q_den  = 32'sh10000000 - ((qc_reg + qd_reg) <<< 1);
        la33   = {2'b00, la_reg};
        prev33 = {1'b0, prevd_reg};
        hit    = !first_reg && !tf_reg && (prev33 <= la33) && (d_reg >= la33);
        cerr   = la33 - prev33;
        nerr   = d_reg - la33;
        at_goal = (d_reg <= {2'b00, tol_reg});
        sharp  = (dd_reg >= QUARTER) || (dd_reg <= NEG_QUARTER);
        dm     = dd_reg[31] ? 32'(-dd_reg) : 32'(dd_reg);
        spd20  = ({11'b0, spd_reg} << 4) + ({11'b0, spd_reg} << 2);
        s_mag  = cor_yo[CW-1] ? CW'(-cor_yo) : CW'(cor_yo);
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a0     = '0;
        mul_b0     = '0;
        mul_a1     = '0;
        mul_b1     = '0;
        sq_start   = 1'b0;
        sq_in      = {1'b0, mul_p0} + {1'b0, mul_p1};
        cor_start  = 1'b0;
        cor_mode   = CM_VECTOR;
        cor_x      = CW'(q_den);
        cor_y      = CW'(q_num);
        cor_z      = ZW'(dd_reg);
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    if (s_path_empty) state_next = S_OUT;
                    else if (s_first_point) state_next = S_QSUM;
                    else state_next = S_DIST;
                end
            end
            S_QSUM: begin
                cor_start  = 1'b1;
                state_next = S_YAW;
            end
            S_YAW: begin
                if (cor_done) state_next = S_DIST;
            end
            S_DIST: begin
                mul_start  = 1'b1;
                mul_a0     = abs_s33(pdx);
                mul_b0     = abs_s33(pdx);
                mul_a1     = abs_s33(pdy);
                mul_b1     = abs_s33(pdy);
                state_next = S_DMUL;
            end
            S_DMUL: begin
                if (mul_done) begin
                    sq_start   = 1'b1;
                    state_next = S_DSQRT;
                end
            end
            S_DSQRT: begin
                if (sq_done) state_next = S_LOOK;
            end
            S_LOOK: begin
                if (!last_reg) state_next = S_IDLE;
                else if (at_goal) state_next = S_OUT;
                else state_next = S_TGT;
            end
            S_TGT: begin
                cor_start  = 1'b1;
                cor_x      = CW'(tdx);
                cor_y      = CW'(tdy);
                state_next = S_TANG;
            end
            S_TANG: begin
                if (cor_done) state_next = S_HEAD;
            end
            S_HEAD: begin
                if (sharp) begin
                    mul_start  = 1'b1;
                    mul_a0     = dm;
                    mul_b0     = PI_Q29;
                    state_next = S_SHARP1;
                end else if (dd_reg == '0) begin
                    state_next = S_OUT;
                end else begin
                    cor_start  = 1'b1;
                    cor_mode   = CM_ROTATE;
                    cor_x      = GAIN_Q30;
                    cor_y      = '0;
                    state_next = S_SINE;
                end
            end
            S_SHARP1: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a0     = spd20;
                    mul_b0     = mul_p0[PW-1:MW];
                    state_next = S_SHARP2;
                end
            end
            S_SHARP2: begin
                if (mul_done) state_next = S_OUT;
            end
            S_SINE: begin
                if (cor_done) begin
                    mul_start  = 1'b1;
                    mul_a0     = {11'b0, spd_reg};
                    mul_b0     = s_mag[MW-1:0];
                    state_next = S_SMUL;
                end
            end
            S_SMUL: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a0     = abs_s33(tdx_reg);
                    mul_b0     = abs_s33(tdx_reg);
                    mul_a1     = abs_s33(tdy_reg);
                    mul_b1     = abs_s33(tdy_reg);
                    state_next = S_TMUL;
                end
            end
            S_TMUL: begin
                if (mul_done) begin
                    sq_start   = 1'b1;
                    state_next = S_TSQRT;
                end
            end
            S_TSQRT: begin
                if (sq_done) begin
                    if (sq_root == '0) begin
                        state_next = S_OUT;
                    end else begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) state_next = S_OUT;
            end
            S_OUT: begin
                if (out_load) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            la_reg      <= 31'd65536;
            tol_reg     <= 31'd32768;
            spd_reg     <= 21'd32768;
            held_x_reg  <= '0;
            held_y_reg  <= '0;
            yaw_reg     <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            prevd_reg   <= '0;
            tf_reg      <= 1'b0;
            tx_reg      <= '0;
            ty_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_LOOKAHEAD: la_reg  <= pwdata[30:0];
                    REG_TOLERANCE: tol_reg <= pwdata[30:0];
                    REG_SPEED:     spd_reg <= pwdata[20:0];
                    default: ;
                endcase
            end

            if (m_valid_reg && m_ready && !out_load) m_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE: begin
                    if (s_acc) begin
                        px_reg    <= s_point_x;
                        py_reg    <= s_point_y;
                        first_reg <= s_first_point;
                        last_reg  <= s_last_point;
                        qa_reg    <= s_quat_x * s_quat_y;
                        qb_reg    <= s_quat_z * s_quat_w;
                        qc_reg    <= s_quat_y * s_quat_y;
                        qd_reg    <= s_quat_z * s_quat_z;
                        if (s_path_empty) begin
                            tf_reg         <= 1'b0;
                            res_spd_reg    <= '0;
                            res_turn_reg   <= '0;
                            res_status_reg <= ST_NOPATH;
                        end else if (s_first_point) begin
                            held_x_reg <= s_robot_x;
                            held_y_reg <= s_robot_y;
                            tf_reg     <= 1'b0;
                        end
                    end
                end
                S_YAW: begin
                    if (cor_done) yaw_reg <= cor_zo[31:0];
                end
                S_DSQRT: begin
                    if (sq_done) d_reg <= sq_root;
                end
                S_LOOK: begin
                    if (hit) begin
                        // take the pair member nearer the radius, earlier on a tie
                        tx_reg <= (cerr <= nerr) ? prev_x_reg : px_reg;
                        ty_reg <= (cerr <= nerr) ? prev_y_reg : py_reg;
                        tf_reg <= 1'b1;
                    end
                    prev_x_reg <= px_reg;
                    prev_y_reg <= py_reg;
                    prevd_reg  <= d_reg[32] ? 32'hFFFFFFFF : d_reg[31:0];
                    res_spd_reg    <= '0;
                    res_turn_reg   <= '0;
                    res_status_reg <= ST_GOAL;
                end
                S_TGT: begin
                    tdx_reg <= tdx;
                    tdy_reg <= tdy;
                end
                S_TANG: begin
                    if (cor_done) dd_reg <= signed'(cor_zo[31:0] - yaw_reg);
                end
                S_HEAD: begin
                    res_spd_reg    <= spd_reg;
                    res_turn_reg   <= '0;
                    res_status_reg <= ST_STRAIGHT;
                end
                S_SHARP2: begin
                    if (mul_done) begin
                        res_turn_reg   <= sat_s32({28'b0, mul_p0[PW-1:28]}, dd_reg[31]);
                        res_status_reg <= ST_SHARP;
                    end
                end
                S_SINE: begin
                    if (cor_done) sneg_reg <= cor_yo[CW-1];
                end
                S_SMUL: begin
                    if (mul_done) num_reg <= {mul_p0[DIV_NW-2:0], 1'b0};
                end
                S_TSQRT: begin
                    // zero target distance: clamp with the sign of the sine
                    res_turn_reg   <= (num_reg == '0) ? '0 :
                                      sat_s32(64'hFFFFFFFF, sneg_reg);
                    res_status_reg <= ST_ARC;
                end
                S_DIV: begin
                    if (div_done) res_turn_reg <= sat_s32(64'(div_q), sneg_reg);
                end
                S_OUT: begin
                    if (out_load) begin
                        m_valid_reg  <= 1'b1;
                        m_spd_reg    <= res_spd_reg;
                        m_turn_reg   <= res_turn_reg;
                        m_status_reg <= res_status_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    pps_mul u_mul0 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a0),
        .op_b    (mul_b0),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_p0)
    );

    pps_mul u_mul1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a1),
        .op_b    (mul_b1),
        .busy    (),
        .done    (),
        .product (mul_p1)
    );

    pps_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (sq_in),
        .done     (sq_done),
        .root     (sq_root)
    );

    pps_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cor_start),
        .mode    (cor_mode),
        .x_in    (cor_x),
        .y_in    (cor_y),
        .z_in    (cor_z),
        .busy    (cor_busy),
        .done    (cor_done),
        .y_out   (cor_yo),
        .z_out   (cor_zo)
    );

    pps_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  ({sq_root, 14'b0}),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_valid            = m_valid_reg;
    assign m_forward_velocity = m_spd_reg;
    assign m_turn_rate        = m_turn_reg;
    assign m_status           = m_status_reg;

`ifndef SYNTHESIS
    a_cor_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cor_start |-> !cor_busy) else $error("CORDIC started while busy");
    a_mul_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_busy) else $error("multiplier started while busy");
    a_stop_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_GOAL || m_status == ST_NOPATH)
        |-> m_forward_velocity == '0 && m_turn_rate == '0)
        else $error("stop result carries motion");
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("second request taken early");
`endif

endmodule

// ----- rtl/pps_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pps_mul
    import pps_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [MW-1:0] op_a,
    input  logic [MW-1:0] op_b,
    output logic          busy,
    output logic          done,
    output logic [PW-1:0] product
);

    localparam int CNT_W = $clog2(MW);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [MW-1:0]    a_reg;
    logic [PW-1:0]    p_reg;
    logic [MW-1:0]    addend;
    logic [MW:0]      sum;
    logic [PW-1:0]    p_next;

    always_comb begin
        addend = p_reg[0] ? a_reg : '0;
        sum    = {1'b0, p_reg[PW-1:MW]} + {1'b0, addend};
        p_next = {sum, p_reg[MW-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                a_reg    <= op_a;
                p_reg    <= {{MW{1'b0}}, op_b};
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                p_reg   <= p_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = p_reg;

endmodule

// ----- rtl/pps_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_sqrt
// Floor square root, one radicand digit pair per cycle.
// ----------------------------------------------------------------------------
module pps_sqrt
    import pps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [SQ_IN_W-1:0] radicand,
    output logic               done,
    output logic [ROOT_W-1:0]  root
);

    localparam int OP_W  = 2 * ROOT_W;
    localparam int CNT_W = $clog2(ROOT_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [OP_W-1:0]     op_reg;
    logic [SQ_REM_W-1:0] rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [SQ_REM_W-1:0] rem_sh;
    logic [SQ_REM_W-1:0] trial;
    logic                fits;

    always_comb begin
        rem_sh = {rem_reg[SQ_REM_W-3:0], op_reg[OP_W-1:OP_W-2]};
        trial  = {2'b00, root_reg, 2'b01};
        fits   = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                op_reg   <= OP_W'(radicand);
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                op_reg   <= {op_reg[OP_W-3:0], 2'b00};
                rem_reg  <= fits ? rem_sh - trial : rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], fits};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- rtl/pps_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pps_div
    import pps_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_DW-1:0] divisor,
    output logic              done,
    output logic [DIV_NW-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_NW);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIV_DW:0]   rem_reg;
    logic [DIV_NW-1:0] q_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW:0]   rem_sh;
    logic              fits;

    always_comb begin
        rem_sh = {rem_reg[DIV_DW-1:0], q_reg[DIV_NW-1]};
        fits   = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                q_reg    <= dividend;
                den_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= fits ? rem_sh - {1'b0, den_reg} : rem_sh;
                q_reg   <= {q_reg[DIV_NW-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- rtl/pps_cordic.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_cordic
// Iterative CORDIC, one micro-rotation per cycle: vectoring for atan2,
// rotation for sine.
// ----------------------------------------------------------------------------
module pps_cordic
    import pps_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic                 mode,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [ZW-1:0] z_in,
    output logic                 busy,
    output logic                 done,
    output logic signed [CW-1:0] y_out,
    output logic signed [ZW-1:0] z_out
);

    localparam logic [5:0] LAST = 6'(CORDIC_STEPS);

    logic                 busy_reg;
    logic                 done_reg;
    logic                 mode_reg;
    logic [5:0]           cnt_reg;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [4:0]           idx;
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [ZW-1:0] ang;
    logic                 ccw;
    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_next;
    logic signed [ZW-1:0] z_next;

    always_comb begin
        idx = cnt_reg[4:0];
        sx  = x_reg >>> idx;
        sy  = y_reg >>> idx;
        ang = {2'b00, atan_bam(idx)};
        ccw = (mode_reg == CM_VECTOR) ? y_reg[CW-1] : !z_reg[ZW-1];
        if (ccw) begin
            x_next = x_reg - sy;
            y_next = y_reg + sx;
            z_next = z_reg - ang;
        end else begin
            x_next = x_reg + sy;
            y_next = y_reg - sx;
            z_next = z_reg + ang;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                mode_reg <= mode;
                cnt_reg  <= '0;
                if (mode == CM_ROTATE) begin
                    x_reg <= x_in;
                    y_reg <= y_in;
                    z_reg <= z_in;
                end else if (x_in == '0 && y_in == '0) begin
                    // zero vector: angle zero, skip the iterations
                    x_reg   <= '0;
                    y_reg   <= '0;
                    z_reg   <= '0;
                    cnt_reg <= LAST;
                end else if (x_in[CW-1]) begin
                    // fold the left half plane by a quarter turn
                    if (!y_in[CW-1]) begin
                        x_reg <= y_in;
                        y_reg <= -x_in;
                        z_reg <= {2'b00, 32'h40000000};
                    end else begin
                        x_reg <= -y_in;
                        y_reg <= x_in;
                        z_reg <= {2'b00, 32'hC0000000};
                    end
                end else begin
                    x_reg <= x_in;
                    y_reg <= y_in;
                    z_reg <= '0;
                end
            end else if (busy_reg) begin
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    x_reg   <= x_next;
                    y_reg   <= y_next;
                    z_reg   <= z_next;
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign busy  = busy_reg;
    assign done  = done_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// ----- tb/pure_pursuit_steering_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pure_pursuit_steering_tb
// Streams path requests into the steering block under random idling on both
// channels, predicts every command with an in-bench model of the pursuit
// maths, and checks each command field by field across several register
// settings.
// ----------------------------------------------------------------------------
module pure_pursuit_steering_tb
    import pps_pkg::*;
();

    localparam int N_STEPS = CORDIC_STEPS_DEF;
    localparam int SETTLE  = 600;
    localparam logic [3:0] REG_LOOKAHEAD = 4'h0;
    localparam logic [3:0] REG_GOAL_TOL  = 4'h4;
    localparam logic [3:0] REG_SPEED     = 4'h8;

    typedef struct {
        logic signed [31:0] px, py, rx, ry;
        logic first, last, empty;
        logic signed [15:0] qx, qy, qz, qw;
    } point_t;

    typedef struct {
        logic [20:0] vel;
        logic [31:0] turn;
        logic [2:0]  status;
    } command_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_point_x = '0, s_point_y = '0, s_robot_x = '0, s_robot_y = '0;
    logic s_first_point = 1'b0, s_last_point = 1'b0, s_path_empty = 1'b0;
    logic signed [15:0] s_quat_x = '0, s_quat_y = '0, s_quat_z = '0, s_quat_w = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [20:0] m_forward_velocity;
    logic signed [31:0] m_turn_rate;
    logic [2:0] m_status;

    pure_pursuit_steering uut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------- predictor ----------------
    longint unsigned cfg_lookahead = 65536, cfg_goal_tol = 32768, cfg_speed = 32768;
    longint pose_x = 0, pose_y = 0;
    logic [31:0] pose_yaw = '0;
    longint last_px = 0, last_py = 0;
    longint unsigned last_dist = 0;
    bit aim_found = 0;
    longint aim_x = 0, aim_y = 0;

    command_t cmd_q[$];
    point_t   pending[$];
    int       errors = 0;

    longint atan_tab[32] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
        64'h00000001, 64'h00000000};

    function automatic longint unsigned path_dist(longint dx, longint dy);
        logic [65:0] sum;
        longint unsigned a, b, rem, root, trial;
        a = dx < 0 ? -dx : dx;
        b = dy < 0 ? -dy : dy;
        sum = 66'(a * a) + 66'(b * b);
        rem = 0;
        root = 0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | longint'(sum[2*i +: 2]);
            root = root << 1;
            trial = (root << 1) | 1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = root | 1;
            end
        end
        return root;
    endfunction

    function automatic logic [31:0] bearing(longint x, longint y);
        logic [31:0] z;
        longint t, nx, ny;
        z = '0;
        if (x == 0 && y == 0) return '0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = 32'h40000000;
            end else begin
                x = -y; y = t; z = 32'hC0000000;
            end
        end
        for (int i = 0; i < N_STEPS; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); ny = y - (x >>> i); z = z + 32'(atan_tab[i]);
            end else begin
                nx = x - (y >>> i); ny = y + (x >>> i); z = z - 32'(atan_tab[i]);
            end
            x = nx; y = ny;
        end
        return z;
    endfunction

    function automatic longint sine_q30(longint a);
        longint x, y, z, nx, ny;
        x = 652032874; y = 0; z = a;
        for (int i = 0; i < N_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); ny = y + (x >>> i); z = z - atan_tab[i];
            end else begin
                nx = x + (y >>> i); ny = y - (x >>> i); z = z + atan_tab[i];
            end
            x = nx; y = ny;
        end
        return y;
    endfunction

    function automatic logic [31:0] clamp32(longint unsigned mag, bit neg);
        if (neg) return mag >= 64'h80000000 ? 32'h80000000 : 32'(-longint'(mag));
        return mag > 64'h7FFFFFFF ? 32'h7FFFFFFF : mag[31:0];
    endfunction

    task automatic pursue_step(input point_t p);
        longint px, py, qx, qy, qz, qw, num, den, tx, ty, dd;
        longint unsigned span, dm, rad28, mag, nm, dt, ce, ne;
        logic [31:0] u;
        longint s;
        command_t c;
        if (p.empty) begin
            aim_found = 0;
            cmd_q.push_back('{21'd0, 32'd0, ST_NOPATH});
            return;
        end
        px = p.px; py = p.py;
        if (p.first) begin
            qx = p.qx; qy = p.qy; qz = p.qz; qw = p.qw;
            num = 2 * (qx * qy + qz * qw);
            den = (longint'(1) << 28) - 2 * (qy * qy + qz * qz);
            pose_x = p.rx; pose_y = p.ry;
            pose_yaw = bearing(den, num);
            aim_found = 0;
        end
        span = path_dist(px - pose_x, py - pose_y);
        if (!p.first && !aim_found && last_dist <= cfg_lookahead && span >= cfg_lookahead) begin
            ce = cfg_lookahead - last_dist;
            ne = span - cfg_lookahead;
            if (ce <= ne) begin
                aim_x = last_px; aim_y = last_py;
            end else begin
                aim_x = px; aim_y = py;
            end
            aim_found = 1;
        end
        last_px = px; last_py = py;
        last_dist = span > 64'hFFFFFFFF ? 64'hFFFFFFFF : span;
        if (!p.last) return;
        if (span <= cfg_goal_tol) begin
            cmd_q.push_back('{21'd0, 32'd0, ST_GOAL});
            return;
        end
        tx = aim_found ? aim_x : px;
        ty = aim_found ? aim_y : py;
        c.vel = cfg_speed[20:0];
        c.turn = '0;
        u = bearing(tx - pose_x, ty - pose_y) - pose_yaw;
        dd = longint'(signed'(u));
        dm = dd < 0 ? -dd : dd;
        if (dd >= 64'sh40000000 || dd <= -64'sh40000000) begin
            rad28 = (dm * 64'd1686629713) >> 32;
            mag = (20 * cfg_speed * rad28) >> 28;
            c.turn = clamp32(mag, dd < 0);
            c.status = ST_SHARP;
        end else if (dd == 0) begin
            c.status = ST_STRAIGHT;
        end else begin
            s = sine_q30(dd);
            nm = 2 * cfg_speed * longint'(s < 0 ? -s : s);
            dt = path_dist(tx - pose_x, ty - pose_y);
            if (dt == 0) mag = nm == 0 ? 0 : 64'hFFFFFFFF;
            else mag = nm / (dt << 14);
            c.turn = clamp32(mag, s < 0);
            c.status = ST_ARC;
        end
        cmd_q.push_back(c);
    endtask

    // ---------------- driver ----------------
    point_t cur;
    bit s_taken = 0, m_taken = 0, calm = 0;
    int s_gap = 0, m_gap = 0;

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    always @(posedge aclk) begin
        s_taken <= s_valid && s_ready;
        if (s_valid && s_ready) pursue_step(cur);
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (s_gap > 0) begin
                s_valid <= 1'b0;
                s_gap = s_gap - 1;
            end else if (pending.size() > 0) begin
                cur = pending.pop_front();
                s_point_x <= cur.px;  s_point_y <= cur.py;
                s_robot_x <= cur.rx;  s_robot_y <= cur.ry;
                s_first_point <= cur.first;
                s_last_point <= cur.last;
                s_path_empty <= cur.empty;
                s_quat_x <= cur.qx;  s_quat_y <= cur.qy;
                s_quat_z <= cur.qz;  s_quat_w <= cur.qw;
                s_valid <= 1'b1;
                s_gap = draw_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_gap > 0 && (!m_ready || m_taken)) begin
            m_ready <= 1'b0;
            m_gap = m_gap - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        command_t e;
        m_taken <= m_valid && m_ready;
        if (aresetn && m_valid && m_ready) begin
            m_gap = draw_gap();
            if (cmd_q.size() == 0) begin
                $error("unexpected command: vel %0d turn %0d status %0d",
                       m_forward_velocity, m_turn_rate, m_status);
                errors++;
            end else begin
                e = cmd_q.pop_front();
                if (m_forward_velocity !== e.vel) begin
                    $error("forward_velocity: expected %0d, got %0d", e.vel, m_forward_velocity);
                    errors++;
                end
                if (m_turn_rate !== e.turn) begin
                    $error("turn_rate: expected %0d, got %0d",
                           $signed(e.turn), m_turn_rate);
                    errors++;
                end
                if (m_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_status);
                    errors++;
                end
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic reg_write(input logic [3:0] addr, input logic [31:0] val);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= addr; pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (addr)
            REG_LOOKAHEAD: cfg_lookahead = val & 32'h7FFFFFFF;
            REG_GOAL_TOL:  cfg_goal_tol = val & 32'h7FFFFFFF;
            default:       cfg_speed = val & 32'h1FFFFF;
        endcase
    endtask

    task automatic drain();
        while (pending.size() > 0 || s_valid || cmd_q.size() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic point_t rnd_point();
        point_t p;
        p.px = $urandom; p.py = $urandom; p.rx = $urandom; p.ry = $urandom;
        p.qx = $urandom_range(0, 32768) - 16384;
        p.qy = $urandom_range(0, 32768) - 16384;
        p.qz = $urandom_range(0, 32768) - 16384;
        p.qw = $urandom_range(0, 32768) - 16384;
        p.first = $urandom_range(0, 1);
        p.last = $urandom_range(0, 1);
        p.empty = $urandom_range(0, 15) == 0;
        return p;
    endfunction

    function automatic point_t pt(longint x, longint y, longint rx, longint ry,
                                  bit f, bit l, int qz, int qw);
        point_t p;
        p = '{px: x, py: y, rx: rx, ry: ry, first: f, last: l, empty: 0,
              qx: 0, qy: 0, qz: qz, qw: qw};
        return p;
    endfunction

    // well-formed path walking outwards from the robot
    task automatic add_path(input int n);
        longint rx, ry, sx, sy;
        int qz, qw;
        point_t p;
        rx = $urandom_range(0, 1 << 24) - (1 << 23);
        ry = $urandom_range(0, 1 << 24) - (1 << 23);
        sx = $urandom_range(0, 3 << 16) - (3 << 15);
        sy = $urandom_range(0, 3 << 16) - (3 << 15);
        qz = $urandom_range(0, 32768) - 16384;
        qw = $urandom_range(0, 32768) - 16384;
        for (int k = 0; k < n; k++) begin
            p = pt(rx + k * sx + $urandom_range(0, 4095), ry + k * sy,
                   rx, ry, k == 0, k == n - 1, qz, qw);
            if ($urandom_range(0, 7) == 0) begin
                p.qx = $urandom_range(0, 32768) - 16384;
                p.qy = $urandom_range(0, 32768) - 16384;
            end
            pending.push_back(p);
        end
    endtask

    task automatic random_phase(input int n_items);
        int cnt;
        cnt = 0;
        while (cnt < n_items) begin
            if ($urandom_range(0, 29) == 0) calm = !calm;
            if ($urandom_range(0, 3) != 0) begin
                add_path($urandom_range(1, 8));
                cnt = cnt + 4;
            end else begin
                pending.push_back(rnd_point());
                cnt++;
            end
        end
    endtask

    initial begin
        point_t e;
        e = '{default: 0};
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty path, goal on the spot, straight, behind, extremes
        e.empty = 1;
        pending.push_back(e);
        pending.push_back(pt(0, 0, 0, 0, 1, 1, 0, 16384));
        pending.push_back(pt(3 << 16, 0, 0, 0, 1, 1, 0, 16384));
        pending.push_back(pt(0, 0, 0, 0, 1, 0, 0, 16384));
        pending.push_back(pt(1 << 16, 0, 0, 0, 0, 0, 0, 16384));
        pending.push_back(pt(2 << 16, 1 << 15, 0, 0, 0, 1, 0, 16384));
        pending.push_back(pt(-(3 << 16), 0, 0, 0, 1, 1, 0, 16384));
        pending.push_back(pt(-(3 << 16), -1, 0, 0, 1, 1, 16384, 0));
        pending.push_back(pt(32'sh7FFFFFFF, 32'sh7FFFFFFF,
                             -32'sh80000000, -32'sh80000000, 1, 1, -16384, 16384));
        pending.push_back(pt(-32'sh80000000, 32'sh7FFFFFFF,
                             32'sh7FFFFFFF, 0, 1, 0, 16384, -16384));
        pending.push_back(pt(1 << 17, 1 << 17, 0, 0, 0, 1, 0, 0));
        pending.push_back(pt(1 << 18, 5, 0, 0, 0, 1, 0, 0));
        pending.push_back(pt(0, 1 << 18, 0, 0, 0, 1, 0, 0));
        e = pt(1 << 18, 1 << 18, 0, 0, 1, 1, 0, 0);
        e.qx = 16384; e.qy = -16384;
        pending.push_back(e);
        drain();

        random_phase(100);
        drain();
        reg_write(REG_LOOKAHEAD, 32'h0);
        reg_write(REG_GOAL_TOL, 32'h0);
        reg_write(REG_SPEED, 32'h0);
        random_phase(80);
        drain();
        reg_write(REG_LOOKAHEAD, 32'h7FFFFFFF);
        reg_write(REG_GOAL_TOL, 32'h7FFFFFFF);
        reg_write(REG_SPEED, 32'd1048576);
        random_phase(40);
        drain();
        reg_write(REG_GOAL_TOL, 32'h0);
        random_phase(80);
        drain();
        reg_write(REG_LOOKAHEAD, 32'd131072);
        reg_write(REG_SPEED, 32'd1048576);
        random_phase(120);
        drain();
        reg_write(REG_LOOKAHEAD, $urandom_range(0, 5 << 16));
        reg_write(REG_GOAL_TOL, $urandom_range(0, 1 << 16));
        reg_write(REG_SPEED, $urandom_range(0, 1048576));
        random_phase(120);
        drain();

        if (errors == 0 && cmd_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            if (cmd_q.size() != 0) $error("%0d commands never arrived", cmd_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
